>>> rtl/core/rv32i_instruction_step_top_defines.svh
// assertion macros shared by the rv32i instruction step core
`ifndef RV32I_INSTRUCTION_STEP_TOP_DEFINES_SVH
`define RV32I_INSTRUCTION_STEP_TOP_DEFINES_SVH

// same-cycle implication
`define RVIS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define RVIS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/core/rvis_pkg.sv
// shared types, codes and helper functions of the rv32i instruction step core
package rvis_pkg;

	localparam int MEM_BYTES_DEF = 65536;
	localparam logic [31:0] MEM_BASE_DEF = 32'h8000_0000;
	localparam logic [31:0] HALT_WORD = 32'h0010_0073;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_SETPC = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_PASS = 3'd1;
	localparam logic [2:0] STAT_FAIL = 3'd2;
	localparam logic [2:0] STAT_ILL = 3'd3;
	localparam logic [2:0] STAT_OOB = 3'd4;

	localparam logic [6:0] OP_LUI = 7'b0110111;
	localparam logic [6:0] OP_AUIPC = 7'b0010111;
	localparam logic [6:0] OP_JAL = 7'b1101111;
	localparam logic [6:0] OP_JALR = 7'b1100111;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LOAD = 7'b0000011;
	localparam logic [6:0] OP_STORE = 7'b0100011;
	localparam logic [6:0] OP_IMM = 7'b0010011;
	localparam logic [6:0] OP_REG = 7'b0110011;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SR = 3'd5;
	localparam logic [2:0] F3_OR = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;

	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB = 3'd0;
	localparam logic [2:0] F3_LH = 3'd1;
	localparam logic [2:0] F3_LW = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DECODE,
		ST_EXEC,
		ST_LOAD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic ill;
		logic wr;
		logic is_load;
		logic is_store;
		logic [2:0] nbytes;
		logic [31:0] wv;
		logic [31:0] nxt;
		logic [31:0] ea;
	} exec_res_t;

	function automatic logic span_ok(input logic [31:0] a, input logic [2:0] n,
		input logic [31:0] base, input logic [32:0] size);
		logic [32:0] d;
		logic [32:0] e;
		d = {1'b0, a} - {1'b0, base};
		e = {1'b0, d[31:0]} + {30'b0, n};
		return !d[32] && (e <= size);
	endfunction

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic [31:0] x,
		input logic [31:0] y, input logic alt);
		logic [4:0] sh;
		logic [31:0] r;
		sh = y[4:0];
		case (f3)
			F3_ADD: r = alt ? x - y : x + y;
			F3_SLL: r = x << sh;
			F3_SLT: r = {31'b0, $signed(x) < $signed(y)};
			F3_SLTU: r = {31'b0, x < y};
			F3_XOR: r = x ^ y;
			F3_SR: r = alt ? 32'($signed(x) >>> sh) : x >> sh;
			F3_OR: r = x | y;
			default: r = x & y;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/rvis_if.sv
// request and response channel interfaces
interface rvis_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [15:0] load_addr;
	logic [7:0] load_byte;
	logic [31:0] new_pc;

	modport source(output valid, output cmd, output load_addr, output load_byte,
		output new_pc, input ready);
	modport sink(input valid, input cmd, input load_addr, input load_byte,
		input new_pc, output ready);
endinterface

interface rvis_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] exec_pc;
	logic [31:0] instr_word;
	logic [31:0] next_pc;
	logic wb_enable;
	logic [4:0] wb_reg;
	logic [31:0] wb_value;

	modport source(output valid, output status, output exec_pc, output instr_word,
		output next_pc, output wb_enable, output wb_reg, output wb_value, input ready);
	modport sink(input valid, input status, input exec_pc, input instr_word,
		input next_pc, input wb_enable, input wb_reg, input wb_value, output ready);
endinterface

>>> rtl/core/rv32i_instruction_step_top.sv
// rv32i instruction step core: byte memory banks, register file and sequencer
// One transaction in, one result out. The byte memory sits in four byte-lane
// single-port RAM banks and the register file in two RAM copies, all with a
// registered read. A write-byte, set-pc or unused command passes the start and
// finish states, an executed instruction also decode and execute, and a load
// also the load state, for the bank read for the fetch, the register file read
// and the second bank read for load data. Memory contents are undefined until
// written; the register file reads zero after reset. A finished result may
// wait in the output register while the next transaction is taken.
`include "rv32i_instruction_step_top_defines.svh"
module rv32i_instruction_step_top #(
	parameter int MEM_BYTES = rvis_pkg::MEM_BYTES_DEF,
	parameter logic [31:0] MEM_BASE = rvis_pkg::MEM_BASE_DEF
) (
	input logic clk,
	input logic arst_n,
	rvis_req_if.sink req,
	rvis_rsp_if.source rsp
);
	import rvis_pkg::*;

	localparam int BANK_DEPTH = MEM_BYTES / 4;
	localparam int ROW_W = $clog2(BANK_DEPTH);
	localparam int OFF_W = ROW_W + 2;
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

	state_t state_q, state_d;

	logic [1:0] cmd_q;
	logic [15:0] la_q;
	logic [7:0] lb_q;
	logic [31:0] npc_q;
	logic [31:0] pc_q;
	logic [OFF_W-1:0] off_q;
	logic [31:0] instr_q;
	logic [4:0] ra1_q, ra2_q;
	logic [2:0] ld_f3_q;
	logic [4:0] ld_rd_q;
	logic [31:0] ld_nxt_q;
	logic [31:0] rf_valid_q;

	logic [2:0] res_status_q;
	logic [31:0] res_exec_pc_q, res_instr_q, res_next_pc_q, res_wb_val_q;
	logic res_wb_en_q;
	logic [4:0] res_wb_reg_q;

	logic out_valid_q;
	logic [2:0] out_status_q;
	logic [31:0] out_exec_pc_q, out_instr_q, out_next_pc_q, out_wb_val_q;
	logic out_wb_en_q;
	logic [4:0] out_wb_reg_q;

	logic accept, out_free;
	logic [OFF_W-1:0] pc_off, ea_off;
	logic pc_in, la_in, ea_in, halt;
	logic [31:0] mem_word, ld_val;
	logic [31:0] rf_rd1, rf_rd2, rv1, rv2;
	exec_res_t er;

	logic acc_we;
	logic [OFF_W-1:0] acc_off;
	logic [2:0] acc_n;
	logic [31:0] acc_data;
	logic [3:0] bank_we;
	logic [ROW_W-1:0] bank_addr [4];
	logic [7:0] bank_wdata [4];
	logic [7:0] bank_rdata [4];

	logic rf_we;
	logic [4:0] rf_waddr, rf_ra1, rf_ra2;
	logic [31:0] rf_wdata;

	assign accept = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign pc_off = OFF_W'(pc_q - MEM_BASE);
	assign pc_in = span_ok(pc_q, 3'd4, MEM_BASE, MEM_LIMIT);
	assign la_in = {17'b0, la_q} < MEM_LIMIT;
	assign halt = instr_q == HALT_WORD;

	assign rv1 = rf_valid_q[ra1_q] ? rf_rd1 : 32'd0;
	assign rv2 = rf_valid_q[ra2_q] ? rf_rd2 : 32'd0;

	rvis_exec u_exec (
		.instr(instr_q),
		.pc(pc_q),
		.rs1v(rv1),
		.rs2v(rv2),
		.res(er)
	);

	assign ea_in = span_ok(er.ea, er.nbytes, MEM_BASE, MEM_LIMIT);
	assign ea_off = OFF_W'(er.ea - MEM_BASE);

	always_comb begin
		logic [1:0] lane;
		for (int i = 0; i < 4; i++) begin
			lane = off_q[1:0] + 2'(i);
			mem_word[8*i +: 8] = bank_rdata[lane];
		end
	end

	always_comb begin
		case (ld_f3_q)
			F3_LB: ld_val = {{24{mem_word[7]}}, mem_word[7:0]};
			F3_LH: ld_val = {{16{mem_word[15]}}, mem_word[15:0]};
			F3_LBU: ld_val = {24'b0, mem_word[7:0]};
			F3_LHU: ld_val = {16'b0, mem_word[15:0]};
			default: ld_val = mem_word;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (cmd_q == CMD_STEP && pc_in) begin
					state_d = ST_DECODE;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DECODE: state_d = ST_EXEC;
			ST_EXEC: begin
				if (!halt && !er.ill && er.is_load && ea_in) begin
					state_d = ST_LOAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_LOAD: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		acc_we = 1'b0;
		acc_off = '0;
		acc_n = 3'd0;
		acc_data = 32'd0;
		rf_we = 1'b0;
		rf_waddr = 5'd0;
		rf_wdata = 32'd0;
		rf_ra1 = ra1_q;
		rf_ra2 = ra2_q;
		case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_START: begin
				if (cmd_q == CMD_WRITE && la_in) begin
					acc_we = 1'b1;
					acc_off = OFF_W'(la_q);
					acc_n = 3'd1;
					acc_data = {24'b0, lb_q};
				end else begin
					acc_off = pc_off;
					acc_n = 3'd4;
				end
			end
			ST_DECODE: begin
				rf_ra1 = (mem_word == HALT_WORD) ? 5'd10 : mem_word[19:15];
				rf_ra2 = mem_word[24:20];
			end
			ST_EXEC: begin
				if (!halt && !er.ill) begin
					if (er.is_load || er.is_store) begin
						acc_off = ea_off;
						acc_n = er.nbytes;
						acc_data = rv2;
						acc_we = er.is_store && ea_in;
					end else if (er.wr && instr_q[11:7] != 5'd0) begin
						rf_we = 1'b1;
						rf_waddr = instr_q[11:7];
						rf_wdata = er.wv;
					end
				end
			end
			ST_LOAD: begin
				if (ld_rd_q != 5'd0) begin
					rf_we = 1'b1;
					rf_waddr = ld_rd_q;
					rf_wdata = ld_val;
				end
			end
			default: ;
		endcase
	end

	// per-lane bank addressing
	always_comb begin
		logic [1:0] lane;
		logic [OFF_W-1:0] sum;
		for (int k = 0; k < 4; k++) begin
			lane = 2'(k) - acc_off[1:0];
			sum = acc_off + OFF_W'(lane);
			bank_addr[k] = sum[OFF_W-1:2];
			bank_we[k] = acc_we && ({1'b0, lane} < acc_n);
			bank_wdata[k] = 8'(acc_data >> {lane, 3'b000});
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank
		rvis_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk(clk),
			.we(bank_we[k]),
			.addr(bank_addr[k]),
			.wdata(bank_wdata[k]),
			.rdata(bank_rdata[k])
		);
	end

	rvis_ram #(
		.WIDTH(32),
		.DEPTH(32)
	) u_rf_a (
		.clk(clk),
		.we(rf_we),
		.addr(rf_we ? rf_waddr : rf_ra1),
		.wdata(rf_wdata),
		.rdata(rf_rd1)
	);

	rvis_ram #(
		.WIDTH(32),
		.DEPTH(32)
	) u_rf_b (
		.clk(clk),
		.we(rf_we),
		.addr(rf_we ? rf_waddr : rf_ra2),
		.wdata(rf_wdata),
		.rdata(rf_rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= MEM_BASE;
			rf_valid_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
			end
			case (state_q)
				ST_START: begin
					if (cmd_q == CMD_SETPC) begin
						pc_q <= npc_q;
					end
				end
				ST_EXEC: begin
					if (!halt && !er.ill && !(er.is_load && ea_in)) begin
						pc_q <= er.nxt;
					end
				end
				ST_LOAD: pc_q <= ld_nxt_q;
				default: ;
			endcase
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			la_q <= req.load_addr;
			lb_q <= req.load_byte;
			npc_q <= req.new_pc;
			res_exec_pc_q <= pc_q;
		end
		case (state_q)
			ST_START: begin
				res_status_q <= (cmd_q == CMD_STEP && !pc_in) ? STAT_OOB : STAT_OK;
				res_instr_q <= 32'd0;
				res_next_pc_q <= (cmd_q == CMD_SETPC) ? npc_q : pc_q;
				res_wb_en_q <= 1'b0;
				res_wb_reg_q <= 5'd0;
				res_wb_val_q <= 32'd0;
				off_q <= pc_off;
			end
			ST_DECODE: begin
				instr_q <= mem_word;
				res_instr_q <= mem_word;
				ra1_q <= rf_ra1;
				ra2_q <= rf_ra2;
			end
			ST_EXEC: begin
				if (halt) begin
					res_status_q <= (rv1 == 32'd0) ? STAT_PASS : STAT_FAIL;
				end else if (er.ill) begin
					res_status_q <= STAT_ILL;
				end else begin
					res_next_pc_q <= er.nxt;
				end
				if (rf_we) begin
					res_wb_en_q <= 1'b1;
					res_wb_reg_q <= rf_waddr;
					res_wb_val_q <= rf_wdata;
				end
				off_q <= ea_off;
				ld_f3_q <= instr_q[14:12];
				ld_rd_q <= instr_q[11:7];
				ld_nxt_q <= er.nxt;
			end
			ST_LOAD: begin
				if (rf_we) begin
					res_wb_en_q <= 1'b1;
					res_wb_reg_q <= rf_waddr;
					res_wb_val_q <= rf_wdata;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_exec_pc_q <= res_exec_pc_q;
					out_instr_q <= res_instr_q;
					out_next_pc_q <= res_next_pc_q;
					out_wb_en_q <= res_wb_en_q;
					out_wb_reg_q <= res_wb_reg_q;
					out_wb_val_q <= res_wb_val_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.exec_pc = out_exec_pc_q;
	assign rsp.instr_word = out_instr_q;
	assign rsp.next_pc = out_next_pc_q;
	assign rsp.wb_enable = out_wb_en_q;
	assign rsp.wb_reg = out_wb_reg_q;
	assign rsp.wb_value = out_wb_val_q;

	`RVIS_ASSERT_IMP(a_no_x0_write, clk, arst_n, rf_we, rf_waddr != 5'd0)
	`RVIS_ASSERT_IMP(a_bank_write_state, clk, arst_n, |bank_we, state_q == ST_START || state_q == ST_EXEC)
	`RVIS_ASSERT_NXT(a_accept_start, clk, arst_n, req.valid && req.ready, state_q == ST_START)
	`RVIS_ASSERT_NXT(a_fin_hold, clk, arst_n, state_q == ST_FIN && out_valid_q && !rsp.ready, state_q == ST_FIN && out_valid_q)
endmodule

>>> rtl/core/rvis_ram.sv
// generic single-port ram with registered read
module rvis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/core/rvis_exec.sv
// instruction decode, alu, branch and address generation
module rvis_exec (
	input logic [31:0] instr,
	input logic [31:0] pc,
	input logic [31:0] rs1v,
	input logic [31:0] rs2v,
	output rvis_pkg::exec_res_t res
);
	import rvis_pkg::*;

	logic [6:0] op;
	logic [2:0] f3;
	logic alt;
	logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
	logic take;

	assign op = instr[6:0];
	assign f3 = instr[14:12];
	assign alt = instr[30];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_u = {instr[31:12], 12'b0};
	assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};

	always_comb begin
		take = 1'b0;
		res = '0;
		res.nxt = pc + 32'd4;
		res.ea = rs1v + imm_i;
		case (f3[1:0])
			2'd0: res.nbytes = 3'd1;
			2'd1: res.nbytes = 3'd2;
			default: res.nbytes = 3'd4;
		endcase
		case (op)
			OP_LUI: begin
				res.wr = 1'b1;
				res.wv = imm_u;
			end
			OP_AUIPC: begin
				res.wr = 1'b1;
				res.wv = pc + imm_u;
			end
			OP_JAL: begin
				res.wr = 1'b1;
				res.wv = pc + 32'd4;
				res.nxt = pc + imm_j;
			end
			OP_JALR: begin
				if (f3 != 3'd0) begin
					res.ill = 1'b1;
				end else begin
					res.wr = 1'b1;
					res.wv = pc + 32'd4;
					res.nxt = (rs1v + imm_i) & ~32'd1;
				end
			end
			OP_BRANCH: begin
				case (f3)
					F3_BEQ: take = rs1v == rs2v;
					F3_BNE: take = rs1v != rs2v;
					F3_BLT: take = $signed(rs1v) < $signed(rs2v);
					F3_BGE: take = $signed(rs1v) >= $signed(rs2v);
					F3_BLTU: take = rs1v < rs2v;
					F3_BGEU: take = rs1v >= rs2v;
					default: res.ill = 1'b1;
				endcase
				if (take) begin
					res.nxt = pc + imm_b;
				end
			end
			OP_LOAD: begin
				if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU ||
					f3 == F3_LHU) begin
					res.is_load = 1'b1;
				end else begin
					res.ill = 1'b1;
				end
			end
			OP_STORE: begin
				if (f3 > 3'd2) begin
					res.ill = 1'b1;
				end else begin
					res.is_store = 1'b1;
					res.ea = rs1v + imm_s;
				end
			end
			OP_IMM: begin
				res.wr = 1'b1;
				res.wv = alu(f3, rs1v, imm_i, f3 == F3_SR && alt);
			end
			OP_REG: begin
				res.wr = 1'b1;
				res.wv = alu(f3, rs1v, rs2v, (f3 == F3_ADD || f3 == F3_SR) && alt);
			end
			default: res.ill = 1'b1;
		endcase
	end
endmodule

>>> sim/rvis_step_checker.sv
// checker for the rv32i instruction step core: watches both channels, predicts and compares
`timescale 1ns / 1ps
module rvis_step_checker #(
	parameter int MEM_BYTES = rvis_pkg::MEM_BYTES_DEF,
	parameter logic [31:0] MEM_BASE = rvis_pkg::MEM_BASE_DEF
) (
	input logic clk,
	input logic arst_n,
	rvis_req_if req,
	rvis_rsp_if rsp,
	output int fails,
	output int pending
);
	import rvis_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] exec_pc;
		logic [31:0] instr_word;
		logic [31:0] next_pc;
		logic wb_enable;
		logic [4:0] wb_reg;
		logic [31:0] wb_value;
	} step_result_t;

	logic [7:0] mem_model [MEM_BYTES];
	logic [31:0] xreg [32];
	logic [31:0] pc_q;
	step_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic bit in_memory(input logic [31:0] a, input int n, output int off);
		longint d;
		off = 0;
		if (a < MEM_BASE)
			return 0;
		d = longint'({32'b0, a}) - longint'({32'b0, MEM_BASE});
		if (d + n > MEM_BYTES)
			return 0;
		off = int'(d);
		return 1;
	endfunction

	function automatic logic [31:0] alu_result(input logic [2:0] f3, input logic [31:0] x,
		input logic [31:0] y, input logic alt);
		logic [4:0] sh;
		sh = y[4:0];
		case (f3)
			F3_ADD: return alt ? x - y : x + y;
			F3_SLL: return x << sh;
			F3_SLT: return {31'b0, $signed(x) < $signed(y)};
			F3_SLTU: return {31'b0, x < y};
			F3_XOR: return x ^ y;
			F3_SR: return alt ? 32'($signed(x) >>> sh) : x >> sh;
			F3_OR: return x | y;
			default: return x & y;
		endcase
	endfunction

	function automatic step_result_t predict_step(input logic [1:0] cmd,
		input logic [15:0] la, input logic [7:0] lb, input logic [31:0] npc);
		step_result_t r;
		logic [31:0] w, va, vb, nxt, wv, ea, immi, imms, immb, immj;
		logic [6:0] op;
		logic [4:0] rd;
		logic [2:0] f3;
		logic alt, wr, ill, take;
		int off, n;
		r = '0;
		r.exec_pc = pc_q;
		r.next_pc = pc_q;
		wr = 0;
		ill = 0;
		wv = 0;
		case (cmd)
			CMD_WRITE: begin
				if (int'(la) < MEM_BYTES)
					mem_model[la] = lb;
				return r;
			end
			CMD_SETPC: begin
				pc_q = npc;
				r.next_pc = npc;
				return r;
			end
			CMD_STEP: ;
			default: return r;
		endcase
		if (!in_memory(pc_q, 4, off)) begin
			r.status = STAT_OOB;
			return r;
		end
		w = {mem_model[off + 3], mem_model[off + 2], mem_model[off + 1], mem_model[off]};
		r.instr_word = w;
		if (w == HALT_WORD) begin
			r.status = (xreg[10] == 0) ? STAT_PASS : STAT_FAIL;
			return r;
		end
		op = w[6:0];
		rd = w[11:7];
		f3 = w[14:12];
		alt = w[30];
		va = xreg[w[19:15]];
		vb = xreg[w[24:20]];
		nxt = pc_q + 4;
		immi = {{20{w[31]}}, w[31:20]};
		imms = {{20{w[31]}}, w[31:25], w[11:7]};
		immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
		immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
		case (op)
			OP_LUI: begin
				wr = 1;
				wv = {w[31:12], 12'b0};
			end
			OP_AUIPC: begin
				wr = 1;
				wv = pc_q + {w[31:12], 12'b0};
			end
			OP_JAL: begin
				wr = 1;
				wv = pc_q + 4;
				nxt = pc_q + immj;
			end
			OP_JALR: begin
				if (f3 != 0)
					ill = 1;
				else begin
					wr = 1;
					wv = pc_q + 4;
					nxt = (va + immi) & ~32'd1;
				end
			end
			OP_BRANCH: begin
				take = 0;
				case (f3)
					F3_BEQ: take = va == vb;
					F3_BNE: take = va != vb;
					F3_BLT: take = $signed(va) < $signed(vb);
					F3_BGE: take = !($signed(va) < $signed(vb));
					F3_BLTU: take = va < vb;
					F3_BGEU: take = va >= vb;
					default: ill = 1;
				endcase
				if (take)
					nxt = pc_q + immb;
			end
			OP_LOAD: begin
				ea = va + immi;
				n = (f3[1:0] == 0) ? 1 : (f3[1:0] == 1) ? 2 : 4;
				if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU
					|| f3 == F3_LHU) begin
					if (in_memory(ea, n, off)) begin
						wv = 0;
						for (int i = 0; i < n; i++)
							wv |= 32'(mem_model[off + i]) << (8 * i);
						if (f3 == F3_LB)
							wv = {{24{wv[7]}}, wv[7:0]};
						else if (f3 == F3_LH)
							wv = {{16{wv[15]}}, wv[15:0]};
						wr = 1;
					end
				end else
					ill = 1;
			end
			OP_STORE: begin
				if (f3 > 2)
					ill = 1;
				else begin
					ea = va + imms;
					n = 1 << f3;
					if (in_memory(ea, n, off))
						for (int i = 0; i < n; i++)
							mem_model[off + i] = vb[8 * i +: 8];
				end
			end
			OP_IMM: begin
				wr = 1;
				wv = alu_result(f3, va, immi, f3 == F3_SR && alt);
			end
			OP_REG: begin
				wr = 1;
				wv = alu_result(f3, va, vb, (f3 == F3_ADD || f3 == F3_SR) && alt);
			end
			default: ill = 1;
		endcase
		if (ill) begin
			r.status = STAT_ILL;
			return r;
		end
		if (wr && rd != 0) begin
			xreg[rd] = wv;
			r.wb_enable = 1;
			r.wb_reg = rd;
			r.wb_value = wv;
		end
		pc_q = nxt;
		r.next_pc = nxt;
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				xreg[i] = 0;
			pc_q = MEM_BASE;
			expected_q.delete();
			fails = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0)
					report("unexpected transaction", rsp.exec_pc, 0);
				else begin
					e = expected_q.pop_front();
					if (rsp.status !== e.status)
						report("status", 32'(rsp.status), 32'(e.status));
					if (rsp.exec_pc !== e.exec_pc) report("exec_pc", rsp.exec_pc, e.exec_pc);
					if (rsp.instr_word !== e.instr_word)
						report("instr_word", rsp.instr_word, e.instr_word);
					if (rsp.next_pc !== e.next_pc) report("next_pc", rsp.next_pc, e.next_pc);
					if (rsp.wb_enable !== e.wb_enable)
						report("wb_enable", 32'(rsp.wb_enable), 32'(e.wb_enable));
					if (rsp.wb_reg !== e.wb_reg)
						report("wb_reg", 32'(rsp.wb_reg), 32'(e.wb_reg));
					if (rsp.wb_value !== e.wb_value)
						report("wb_value", rsp.wb_value, e.wb_value);
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(predict_step(req.cmd, req.load_addr, req.load_byte,
					req.new_pc));
		end
	end
endmodule

>>> sim/rv32i_instruction_step_top_tb.sv
// testbench top for the rv32i instruction step core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module rv32i_instruction_step_top_tb;
	import rvis_pkg::*;

	localparam logic [31:0] BASE = MEM_BASE_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1150;

	logic clk;
	logic arst_n;
	int fails, pending, items, cycles;
	int snd_idle_pct, rcv_stall_pct;
	bit hold_go;

	rvis_req_if req_ch();
	rvis_rsp_if rsp_ch();

	rv32i_instruction_step_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	rvis_step_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fails(fails),
		.pending(pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL rv32i_instruction_step_top");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		static int hold_left = 0;
		static bit hold_done = 0;
		if (!arst_n)
			rsp_ch.ready <= 0;
		else begin
			if (hold_go && !hold_done) begin
				hold_left = 400;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 0;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	task automatic send(input logic [1:0] cmd, input logic [15:0] la, input logic [7:0] lb,
		input logic [31:0] npc);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_ch.valid <= 0;
			@(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.cmd <= cmd;
		req_ch.load_addr <= la;
		req_ch.load_byte <= lb;
		req_ch.new_pc <= npc;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items++;
	endtask

	task automatic write_word(input logic [15:0] off, input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			send(CMD_WRITE, off + 16'(i), w[8 * i +: 8], $urandom);
	endtask

	task automatic step_at(input logic [31:0] pc);
		send(CMD_SETPC, 16'($urandom), 8'($urandom), pc);
		send(CMD_STEP, 16'($urandom), 8'($urandom), $urandom);
	endtask

	function automatic logic [4:0] pick_rd();
		logic [4:0] r;
		r = 5'($urandom_range(31));
		if (r == 1 || r == 3)
			r = r + 5'd1;
		return r;
	endfunction

	function automatic logic [4:0] pick_rs();
		return ($urandom_range(1)) ? 5'($urandom_range(31)) : 5'($urandom_range(4, 11));
	endfunction

	function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
		input logic [2:0] f3, input logic [4:0] rs1, input logic [11:0] imm);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] data_access(input bit store);
		logic [4:0] base;
		logic [11:0] imm;
		logic [2:0] f3;
		base = $urandom_range(1) ? 5'd1 : 5'd3;
		imm = (base == 1) ? 12'($urandom_range(68) - 8) : 12'($urandom_range(23) - 8);
		if (store) begin
			f3 = ($urandom_range(9) == 0) ? 3'($urandom_range(3, 7)) : 3'($urandom_range(2));
			return {imm[11:5], pick_rs(), base, f3, imm[4:0], OP_STORE};
		end
		f3 = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(5));
		return enc_i(OP_LOAD, pick_rd(), f3, base, imm);
	endfunction

	function automatic logic [31:0] body_word();
		int k;
		logic [6:0] op;
		logic [11:0] imm;
		k = $urandom_range(99);
		if (k < 25) begin
			imm = 12'($urandom);
			if ($urandom_range(1))
				imm = 12'($urandom_range(63) - 32);
			return enc_i(OP_IMM, pick_rd(), 3'($urandom), pick_rs(), imm);
		end
		if (k < 50)
			return {1'b0, 1'($urandom), 5'($urandom), pick_rs(), pick_rs(), 3'($urandom),
				pick_rd(), OP_REG} | ($urandom_range(3) == 0 ? {$urandom} & 32'h8000_0000 : 0);
		if (k < 58)
			return {20'($urandom), pick_rd(), OP_LUI};
		if (k < 63)
			return {20'($urandom), pick_rd(), OP_AUIPC};
		if (k < 78)
			return data_access(0);
		if (k < 90)
			return data_access(1);
		if (k < 94)
			return HALT_WORD;
		do
			op = 7'($urandom);
		while (op == OP_LUI || op == OP_AUIPC || op == OP_JAL || op == OP_JALR
			|| op == OP_BRANCH || op == OP_LOAD || op == OP_STORE || op == OP_IMM
			|| op == OP_REG);
		return {25'($urandom), op};
	endfunction

	function automatic logic [31:0] flow_word();
		logic [20:0] j;
		logic [12:0] b;
		logic [2:0] f3;
		case ($urandom_range(3))
			0: begin
				j = 21'($urandom);
				return {j[20], j[10:1], j[11], j[19:12], pick_rd(), OP_JAL};
			end
			1: begin
				f3 = ($urandom_range(4) == 0) ? 3'($urandom) : 3'd0;
				return enc_i(OP_JALR, pick_rd(), f3, pick_rs(), 12'($urandom));
			end
			2: begin
				b = 13'($urandom);
				return {b[12], b[10:5], pick_rs(), pick_rs(), 3'($urandom), b[4:1], b[11],
					OP_BRANCH};
			end
			default: return body_word();
		endcase
	endfunction

	task automatic run_block(input int blk, input logic [31:0] words[$]);
		logic [15:0] off;
		off = 16'h0100 + 16'((blk % 64) * 32);
		foreach (words[i])
			write_word(off + 16'(4 * i), words[i]);
		repeat ($urandom_range(3) == 0 ? 2 : 1) begin
			send(CMD_SETPC, 16'($urandom), 8'($urandom), BASE + 32'(off));
			foreach (words[i])
				send(CMD_STEP, 16'($urandom), 8'($urandom), $urandom);
		end
	endtask

	task automatic noise();
		logic [31:0] p;
		case ($urandom_range(2))
			0: send(CMD_WRITE, 16'($urandom), 8'($urandom), $urandom);
			1: send(CMD_NOP, 16'($urandom), 8'($urandom), $urandom);
			default: begin
				p = $urandom;
				if (p - BASE < 32'(MEM_BYTES_DEF))
					send(CMD_SETPC, 16'($urandom), 8'($urandom), p);
				else
					step_at(p);
			end
		endcase
	endtask

	initial begin
		logic [31:0] words[$];
		int blk;
		arst_n = 0;
		req_ch.valid <= 0;
		req_ch.cmd <= CMD_WRITE;
		req_ch.load_addr <= 0;
		req_ch.load_byte <= 0;
		req_ch.new_pc <= 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(CMD_NOP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		write_word(16'h0000, HALT_WORD);
		send(CMD_STEP, 0, 0, 0);
		write_word(16'hFFFC, 32'hFFFF_FFFF);
		step_at(BASE + 32'hFFFC);
		step_at(BASE + 32'hFFFD);
		step_at(32'h0000_0000);
		step_at(32'hFFFF_FFFF);
		step_at(BASE - 1);

		for (int i = 4; i < 64; i++)
			send(CMD_WRITE, 16'(i), 8'($urandom), $urandom);
		for (int i = 16'hFFF0; i < 16'hFFFC; i++)
			send(CMD_WRITE, 16'(i), 8'($urandom), $urandom);
		words = '{{20'h80000, 5'd1, OP_LUI}, {20'h80010, 5'd3, OP_LUI},
			enc_i(OP_IMM, 5'd3, F3_ADD, 5'd3, 12'hFF8)};
		run_block(63, words);

		blk = 0;
		while (items < ITEM_TARGET) begin
			case ((blk / 8) % 4)
				0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin snd_idle_pct = 75; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 75; end
				default: begin snd_idle_pct = 6; rcv_stall_pct = 6; end
			endcase
			if (blk == 4)
				hold_go = 1;
			words.delete();
			repeat ($urandom_range(1, 7))
				words.push_back(body_word());
			words.push_back(flow_word());
			run_block(blk, words);
			repeat ($urandom_range(2))
				noise();
			blk++;
		end
		req_ch.valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("PASS rv32i_instruction_step_top");
		else
			$display("FAIL rv32i_instruction_step_top");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rvis_pkg.sv
rtl/core/rvis_if.sv
rtl/core/rvis_ram.sv
rtl/core/rvis_exec.sv
rtl/core/rv32i_instruction_step_top.sv
sim/rvis_step_checker.sv
sim/rv32i_instruction_step_top_tb.sv
